// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int KIND_W          = 3;
  localparam int DEPTH_W         = 5;
  localparam int STATUS_W        = 3;
  localparam int DEF_STACK_DEPTH = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_MOD  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_UNDERFLOW = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DIVZERO   = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_RUN,
    S_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_DIV,
    MDU_MOD
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic push;     // write at sp, sp + 1
    logic replace;  // write at sp - 2, sp - 1
    logic clear;    // sp <= 0, wins over the others
  } stk_cmd_t;

endpackage

// ===== rtl/rpn_mdu.sv =====
// ----------------------------------------------------------------------------
// rpn_mdu
// Iterative signed multiply / divide / modulo. One 34-bit adder shared by
// shift-add multiply and restoring divide, one step per cycle on magnitudes.
// ----------------------------------------------------------------------------
module rpn_mdu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpn_pkg::mdu_req_t              req_i,
  input  logic signed [rpn_pkg::DATA_W-1:0] a_i,
  input  logic signed [rpn_pkg::DATA_W-1:0] b_i,
  output logic                           done_o,
  output logic [rpn_pkg::DATA_W-1:0]     result_o,
  output logic                           ovf_o
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q, fin_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] hi_q, lo_q, m_q;
  logic [DATA_W-1:0] hi_d, lo_d;
  mdu_op_e           op_q;
  logic              sa_q, sb_q;

  logic [DATA_W-1:0] mag_a, mag_b;
  logic              is_mul;
  logic [DATA_W:0]   x, addend;
  logic [DATA_W+1:0] sum;
  logic [2*DATA_W-1:0] prod;
  logic              neg;

  assign mag_a = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
  assign mag_b = b_i[DATA_W-1] ? DATA_W'(-b_i) : DATA_W'(b_i);

  // shared adder: multiply adds the multiplicand, divide subtracts the divisor
  assign is_mul = (op_q == MDU_MUL);
  always_comb begin
    if (is_mul) begin
      x      = {1'b0, hi_q};
      addend = lo_q[0] ? {1'b0, m_q} : '0;
    end else begin
      x      = {hi_q, lo_q[DATA_W-1]};
      addend = ~{1'b0, m_q};
    end
    sum = {1'b0, x} + {1'b0, addend} + {{(DATA_W+1){1'b0}}, ~is_mul};
    if (is_mul) begin
      hi_d = sum[DATA_W:1];
      lo_d = {sum[0], lo_q[DATA_W-1:1]};
    end else if (sum[DATA_W+1]) begin
      hi_d = sum[DATA_W-1:0];
      lo_d = {lo_q[DATA_W-2:0], 1'b1};
    end else begin
      hi_d = x[DATA_W-1:0];
      lo_d = {lo_q[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      sa_q <= a_i[DATA_W-1];
      sb_q <= b_i[DATA_W-1];
      hi_q <= '0;
      if (req_i.op == MDU_MUL) begin
        lo_q <= mag_b;
        m_q  <= mag_a;
      end else begin
        lo_q <= mag_a;
        m_q  <= mag_b;
      end
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  // sign fix-up: quotient and product by sign xor, remainder follows A
  assign prod = {hi_q, lo_q};
  assign neg  = sa_q ^ sb_q;
  always_comb begin
    unique case (op_q)
      MDU_MUL: begin
        result_o = neg ? DATA_W'(-lo_q) : lo_q;
        ovf_o    = neg ? (prod > {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}})
                       : (prod[2*DATA_W-1:DATA_W-1] != '0);
      end
      MDU_DIV: begin
        result_o = neg ? DATA_W'(-lo_q) : lo_q;
        ovf_o    = !neg && lo_q[DATA_W-1];
      end
      default: begin
        result_o = sa_q ? DATA_W'(-hi_q) : hi_q;
        ovf_o    = 1'b0;
      end
    endcase
  end

  assign done_o = fin_q;

endmodule

// ===== rtl/rpn_stack.sv =====
// ----------------------------------------------------------------------------
// rpn_stack
// Operand stack: memory for entries, registered copy of the top, entry count
// and a registered read of the entry below the top.
// ----------------------------------------------------------------------------
module rpn_stack #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int SP_W        = $clog2(STACK_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rpn_pkg::stk_cmd_t            cmd_i,
  input  logic [rpn_pkg::DATA_W-1:0]   wr_value_i,
  output logic [SP_W-1:0]              sp_o,
  output logic [rpn_pkg::DATA_W-1:0]   top_o,
  output logic [rpn_pkg::DATA_W-1:0]   below_o
);
  import rpn_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [DATA_W-1:0] top_q, below_q;
  logic [ADDR_W-1:0] push_addr, below_addr;

  assign push_addr  = sp_q[ADDR_W-1:0];
  assign below_addr = ADDR_W'(sp_q - SP_W'(2));

  always_comb begin
    priority if (cmd_i.clear) begin
      sp_d = '0;
    end else if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end else if (cmd_i.replace) begin
      sp_d = sp_q - 1'b1;
    end else begin
      sp_d = sp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[push_addr] <= wr_value_i;
    end else if (cmd_i.replace) begin
      mem[below_addr] <= wr_value_i;
    end
    if (cmd_i.push || cmd_i.replace) begin
      top_q <= wr_value_i;
    end
    below_q <= mem[below_addr];
  end

  assign sp_o    = sp_q;
  assign top_o   = top_q;
  assign below_o = below_q;

endmodule

// ===== rtl/rpn_stack_calculator_core.sv =====
// Push, add, subtract, unknown kinds, underflow and divide by zero go from decode
//   straight to commit; the next word is accepted only after that word commits.
// Multiply, divide and modulo otherwise pass through the run state, where the
//   shared unit takes its 32 steps before the commit.
// s_axis_tready is low while a word is in flight or its result is stalled.
// Reset: stack empty, no result pending; stack memory is not cleared.
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Reverse Polish evaluator over 32-bit signed integers with status reporting.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  input  logic        s_axis_tlast,   // last_token
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] top_value, [36:32] stack_depth,
                                      // [39:37] status
  output logic        m_axis_tlast    // is_final
);
  import rpn_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  kind_e             kind_q;
  logic [DATA_W-1:0] pv_q, res_q;
  logic              last_q;
  status_e           status_q;

  logic              out_valid_q, out_last_q;
  logic [39:0]       out_data_q;

  stk_cmd_t          stk_cmd;
  logic [SP_W-1:0]   sp;
  logic [DATA_W-1:0] top, below;

  mdu_req_t          mdu_req;
  logic              mdu_done, mdu_ovf;
  logic [DATA_W-1:0] mdu_result;

  logic              accept, commit;
  status_e           dec_status;
  logic              dec_need_mdu;
  mdu_op_e           dec_op;
  logic [DATA_W:0]   addsub;
  logic [DATA_W-1:0] dec_res;
  logic              stk_ok;
  logic [SP_W-1:0]   new_sp;
  logic [DATA_W-1:0] new_top, wr_value;

  rpn_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .SP_W        (SP_W)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .wr_value_i (wr_value),
    .sp_o       (sp),
    .top_o      (top),
    .below_o    (below)
  );

  rpn_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mdu_req),
    .a_i      (below),
    .b_i      (top),
    .done_o   (mdu_done),
    .result_o (mdu_result),
    .ovf_o    (mdu_ovf)
  );

  // decode: A is the registered read below the top, B is the top register
  always_comb begin
    dec_status   = STAT_OK;
    dec_need_mdu = 1'b0;
    dec_op       = MDU_MUL;
    dec_res      = '0;
    addsub       = (kind_q == KIND_SUB)
                 ? {below[DATA_W-1], below} - {top[DATA_W-1], top}
                 : {below[DATA_W-1], below} + {top[DATA_W-1], top};
    unique case (kind_q)
      KIND_PUSH: begin
        if (sp >= SP_W'(STACK_DEPTH)) dec_status = STAT_FULL;
      end
      KIND_ADD, KIND_SUB: begin
        if (sp < SP_W'(2)) begin
          dec_status = STAT_UNDERFLOW;
        end else if (addsub[DATA_W] != addsub[DATA_W-1]) begin
          dec_status = STAT_OVERFLOW;
        end else begin
          dec_res = addsub[DATA_W-1:0];
        end
      end
      KIND_MUL: begin
        if (sp < SP_W'(2)) begin
          dec_status = STAT_UNDERFLOW;
        end else begin
          dec_need_mdu = 1'b1;
        end
      end
      KIND_DIV, KIND_MOD: begin
        dec_op = (kind_q == KIND_DIV) ? MDU_DIV : MDU_MOD;
        if (sp < SP_W'(2)) begin
          dec_status = STAT_UNDERFLOW;
        end else if (top == '0) begin
          dec_status = STAT_DIVZERO;
        end else begin
          dec_need_mdu = 1'b1;
        end
      end
      default: ;  // unknown kind: no operation
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_DECODE;
      S_DECODE: state_d = dec_need_mdu ? S_RUN : S_COMMIT;
      S_RUN:    if (mdu_done) state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready   = (state_q == S_IDLE);
    mdu_req.start   = (state_q == S_DECODE) && dec_need_mdu;
    mdu_req.op      = dec_op;
    stk_ok          = commit && (status_q == STAT_OK);
    stk_cmd.push    = stk_ok && (kind_q == KIND_PUSH);
    stk_cmd.replace = stk_ok && (kind_q == KIND_ADD || kind_q == KIND_SUB ||
                                 kind_q == KIND_MUL || kind_q == KIND_DIV ||
                                 kind_q == KIND_MOD);
    stk_cmd.clear   = commit && last_q;
  end

  // stack state after this word, before any clear by last
  assign wr_value = stk_cmd.push ? pv_q : res_q;
  always_comb begin
    priority if (stk_cmd.push) begin
      new_sp  = sp + 1'b1;
      new_top = pv_q;
    end else if (stk_cmd.replace) begin
      new_sp  = sp - 1'b1;
      new_top = res_q;
    end else begin
      new_sp  = sp;
      new_top = (sp == '0) ? '0 : top;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(s_axis_tuser);
      pv_q   <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (state_q == S_DECODE) begin
      status_q <= dec_status;
      res_q    <= dec_res;
    end else if (state_q == S_RUN && mdu_done) begin
      status_q <= mdu_ovf ? STAT_OVERFLOW : STAT_OK;
      res_q    <= mdu_result;
    end
    if (commit) begin
      out_data_q <= {status_q, DEPTH_W'(new_sp), new_top};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
